// ===== rtl/core/qrf_pkg.sv =====
// Shared widths, register map and status codes of the QR finder row check.
`timescale 1ns / 1ps

package qrf_pkg;

    // Beat field widths
    localparam int PIXEL_W  = 8;
    localparam int STATUS_W = 3;
    localparam int CIDX_W   = 12;
    localparam int CLEN_W   = 13;

    // Configuration register widths and reset values
    localparam int THR_W   = 8;
    localparam int BOUND_W = 5;
    localparam logic [THR_W-1:0]   THR_RESET  = 8'd0;
    localparam logic [BOUND_W-1:0] LOW_RESET  = 5'd6;
    localparam logic [BOUND_W-1:0] HIGH_RESET = 5'd19;

    // APB port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Ratio scale: three over the center length, in tenths
    localparam int RATIO_SCALE = 30;

    // Minimum run count and neighbours per side for a verdict
    localparam int MIN_RUNS = 5;
    localparam int MIN_SIDE = 2;

    // Register index taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_THRESHOLD  = 2'd0,
        REG_RATIO_LOW  = 2'd1,
        REG_RATIO_HIGH = 2'd2
    } t_reg_idx;

    // Verdict codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_FEW_RUNS   = 3'd1,
        ST_FEW_BEFORE = 3'd2,
        ST_FEW_AFTER  = 3'd3,
        ST_RATIO_FAIL = 3'd4
    } t_status;

endpackage

// ===== rtl/core/qrf_if.sv =====
// Valid/ready channel interfaces for pixel beats and verdict beats.
`timescale 1ns / 1ps

interface qrf_pix_if;
    logic                       valid;
    logic                       ready;
    logic [qrf_pkg::PIXEL_W-1:0] pixel;
    logic                       row_end;

    modport source (output valid, output pixel, output row_end, input ready);
    modport sink   (input valid, input pixel, input row_end, output ready);
endinterface

interface qrf_res_if;
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic [qrf_pkg::STATUS_W-1:0] status;
    logic [qrf_pkg::CIDX_W-1:0]   center_index;
    logic [qrf_pkg::CLEN_W-1:0]   center_length;

    modport source (output valid, output found, output status, output center_index,
                    output center_length, input ready);
    modport sink   (input valid, input found, input status, input center_index,
                    input center_length, output ready);
endinterface

// ===== rtl/core/qr_finder_row_ratio_check.sv =====
// Top level of the QR finder 1:1:3:1:1 row run-ratio check.
//
//  channel | dir | handshake      | payload
//  --------+-----+----------------+---------------------------------------------
//  pix     | in  | valid/ready    | pixel[7:0], row_end
//  res     | out | valid/ready    | found, status[2:0], center_index[11:0],
//          |     |                | center_length[12:0]
//  apb     | in  | psel/penable   | paddr[3:0], pwdata/prdata[31:0], pready=1
//
//  One pixel per cycle while no row_end pixel waits for the verdict stage; the
//  rate is set by the read-modify-write loop on the row-state RAM, closed each
//  cycle through the write-back forwarding register. A row_end pixel's verdict
//  passes the RAM read and update, verdict stage capture and output register.
//  Reset clears the valid bits and the in-row flag and loads the register
//  defaults; the first pixel of a row reinitializes the RAM record, so there
//  is no clearing pass.
//  A stalled verdict holds the row_end pixel at the update stage; other
//  pixels keep flowing while a verdict waits in the output register.
`timescale 1ns / 1ps

module qr_finder_row_ratio_check #(
    parameter int ROW_WIDTH = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    qrf_pix_if.sink                     pix,
    qrf_res_if.source                   res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [qrf_pkg::APB_AW-1:0]  paddr,
    input  logic [qrf_pkg::APB_DW-1:0]  pwdata,
    output logic [qrf_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    localparam int LEN_W = $clog2(ROW_WIDTH+1);
    localparam int IDX_W = $clog2(ROW_WIDTH);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(ROW_WIDTH);
    localparam logic [LEN_W-1:0] IDX_SAT = LEN_W'(ROW_WIDTH-1);

    typedef struct packed {
        logic             prev_color;
        logic [LEN_W-1:0] current_run;
        logic [LEN_W-1:0] runs_done;
        logic [LEN_W-1:0] older_run;
        logic [LEN_W-1:0] newer_run;
        logic [LEN_W-1:0] best_length;
        logic [IDX_W-1:0] best_index;
        logic [LEN_W-1:0] before_far;
        logic [LEN_W-1:0] before_near;
        logic [LEN_W-1:0] after_near;
        logic [LEN_W-1:0] after_far;
        logic [1:0]       after_cnt;
    } t_row;

    // Configuration registers
    logic [qrf_pkg::THR_W-1:0]   r_thr;
    logic [qrf_pkg::BOUND_W-1:0] r_low;
    logic [qrf_pkg::BOUND_W-1:0] r_high;
    logic                        cfg_wr;

    // Row-state RAM and its pipeline
    t_row  r_mem [1];
    t_row  r_rd;
    t_row  r_wb;
    logic  r_fwd;
    logic  r_s1_valid;
    logic  r_s1_color;
    logic  r_s1_last;
    logic  r_in_row;

    logic  accept;
    logic  fire2;
    logic  vd_ready;
    t_row  cur;
    t_row  n_state;

    // Close one run into the record
    function automatic t_row close_run(input t_row s, input logic [LEN_W-1:0] len);
        t_row r;
        r = s;
        if (s.runs_done == '0 || len > s.best_length) begin
            r.best_length = len;
            r.best_index  = (s.runs_done < IDX_SAT) ? s.runs_done[IDX_W-1:0]
                                                   : IDX_SAT[IDX_W-1:0];
            r.before_far  = s.older_run;
            r.before_near = s.newer_run;
            r.after_near  = '0;
            r.after_far   = '0;
            r.after_cnt   = 2'd0;
        end else if (s.after_cnt == 2'd0) begin
            r.after_near = len;
            r.after_cnt  = 2'd1;
        end else if (s.after_cnt == 2'd1) begin
            r.after_far = len;
            r.after_cnt = 2'd2;
        end
        r.older_run = s.newer_run;
        r.newer_run = len;
        if (s.runs_done < LEN_MAX) begin
            r.runs_done = s.runs_done + LEN_W'(1);
        end
        return r;
    endfunction

    // APB write and read
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= qrf_pkg::THR_RESET;
            r_low  <= qrf_pkg::LOW_RESET;
            r_high <= qrf_pkg::HIGH_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                qrf_pkg::REG_THRESHOLD:  r_thr  <= pwdata[qrf_pkg::THR_W-1:0];
                qrf_pkg::REG_RATIO_LOW:  r_low  <= pwdata[qrf_pkg::BOUND_W-1:0];
                qrf_pkg::REG_RATIO_HIGH: r_high <= pwdata[qrf_pkg::BOUND_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            qrf_pkg::REG_THRESHOLD:  prdata = qrf_pkg::APB_DW'(r_thr);
            qrf_pkg::REG_RATIO_LOW:  prdata = qrf_pkg::APB_DW'(r_low);
            qrf_pkg::REG_RATIO_HIGH: prdata = qrf_pkg::APB_DW'(r_high);
            default:                 prdata = '0;
        endcase
    end

    // Pipeline control: a row_end pixel needs room in the verdict stage
    assign fire2     = r_s1_valid && (!r_s1_last || vd_ready);
    assign pix.ready = !r_s1_valid || fire2;
    assign accept    = pix.valid && pix.ready;

    // Binarize on accept and read the row record
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            if (pix.ready) begin
                r_s1_valid <= pix.valid;
            end
            if (accept) begin
                r_fwd <= fire2;
            end
        end
        if (accept) begin
            r_s1_color <= (pix.pixel > r_thr);
            r_s1_last  <= pix.row_end;
            r_rd       <= r_mem[0];
        end
    end

    // Update the record: start a row, close a run or extend it
    always_comb begin
        cur = r_fwd ? r_wb : r_rd;
        n_state = cur;
        if (!r_in_row) begin
            n_state             = '0;
            n_state.prev_color  = r_s1_color;
            n_state.current_run = LEN_W'(1);
        end else if (r_s1_color != cur.prev_color) begin
            n_state             = close_run(cur, cur.current_run);
            n_state.prev_color  = r_s1_color;
            n_state.current_run = LEN_W'(1);
        end else if (cur.current_run < LEN_MAX) begin
            n_state.current_run = cur.current_run + LEN_W'(1);
        end
        if (r_s1_last) begin
            n_state = close_run(n_state, n_state.current_run);
        end
    end

    // Write back and keep a copy for forwarding
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row <= 1'b0;
        end else if (fire2) begin
            r_in_row <= !r_s1_last;
        end
        if (fire2) begin
            r_mem[0] <= n_state;
            r_wb     <= n_state;
        end
    end

    qrf_verdict #(
        .ROW_WIDTH (ROW_WIDTH)
    ) u_verdict (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (fire2 && r_s1_last),
        .o_ready       (vd_ready),
        .i_runs        (n_state.runs_done),
        .i_index       (n_state.best_index),
        .i_len         (n_state.best_length),
        .i_before_far  (n_state.before_far),
        .i_before_near (n_state.before_near),
        .i_after_near  (n_state.after_near),
        .i_after_far   (n_state.after_far),
        .i_after_cnt   (n_state.after_cnt),
        .i_low         (r_low),
        .i_high        (r_high),
        .res           (res)
    );

    // Row flag follows the last pixel of each update
    a_row_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire2 && r_s1_last |=> !r_in_row)
        else $error("row flag still set after row end");

    a_row_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire2 && !r_s1_last |=> r_in_row)
        else $error("row flag clear after mid-row pixel");

    // Inside a row the written record always holds an open run
    a_run_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_row |-> r_wb.current_run != '0)
        else $error("open run of zero length");

    // Forwarding is taken only when the previous update landed on the read edge
    a_fwd_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && fire2 |=> r_fwd)
        else $error("read beside write without forwarding");

    // A stalled update keeps its pixel
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !fire2 |=> r_s1_valid && $stable(r_s1_last))
        else $error("stalled update lost its pixel");

endmodule

// ===== rtl/core/qrf_verdict.sv =====
// Row-end verdict stage: holds the closed row record, checks runs and ratios.
`timescale 1ns / 1ps

module qrf_verdict #(
    parameter int ROW_WIDTH = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [$clog2(ROW_WIDTH+1)-1:0]  i_runs,
    input  logic [$clog2(ROW_WIDTH)-1:0]    i_index,
    input  logic [$clog2(ROW_WIDTH+1)-1:0]  i_len,
    input  logic [$clog2(ROW_WIDTH+1)-1:0]  i_before_far,
    input  logic [$clog2(ROW_WIDTH+1)-1:0]  i_before_near,
    input  logic [$clog2(ROW_WIDTH+1)-1:0]  i_after_near,
    input  logic [$clog2(ROW_WIDTH+1)-1:0]  i_after_far,
    input  logic [1:0]                      i_after_cnt,
    input  logic [qrf_pkg::BOUND_W-1:0]     i_low,
    input  logic [qrf_pkg::BOUND_W-1:0]     i_high,
    qrf_res_if.source                       res
);

    localparam int LEN_W  = $clog2(ROW_WIDTH+1);
    localparam int IDX_W  = $clog2(ROW_WIDTH);
    localparam int PROD_W = LEN_W + qrf_pkg::BOUND_W;

    logic                  r_vd_valid;
    logic [LEN_W-1:0]      r_vd_runs;
    logic [IDX_W-1:0]      r_vd_index;
    logic [LEN_W-1:0]      r_vd_len;
    logic [LEN_W-1:0]      r_vd_bf, r_vd_bn, r_vd_an, r_vd_af;
    logic [1:0]            r_vd_cnt;

    logic                         r_out_valid;
    logic                         r_out_found;
    logic [qrf_pkg::STATUS_W-1:0] r_out_status;
    logic [qrf_pkg::CIDX_W-1:0]   r_out_index;
    logic [qrf_pkg::CLEN_W-1:0]   r_out_len;

    logic                         out_ok;
    logic [PROD_W-1:0]            lo_lim, hi_lim;
    qrf_pkg::t_status             n_status;
    logic [IDX_W+qrf_pkg::CIDX_W-1:0] idx_ext;
    logic [LEN_W+qrf_pkg::CLEN_W-1:0] len_ext;

    // 30*run strictly between the two bound products
    function automatic logic ratio_ok(input logic [LEN_W-1:0] run,
                                      input logic [PROD_W-1:0] lo,
                                      input logic [PROD_W-1:0] hi);
        logic [PROD_W-1:0] scaled;
        scaled = PROD_W'(run) * PROD_W'(qrf_pkg::RATIO_SCALE);
        return (scaled > lo) && (scaled < hi);
    endfunction

    assign out_ok  = !r_out_valid || res.ready;
    assign o_ready = !r_vd_valid || out_ok;

    // Capture the closed row record
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd_valid <= 1'b0;
        end else if (o_ready) begin
            r_vd_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_vd_runs  <= i_runs;
            r_vd_index <= i_index;
            r_vd_len   <= i_len;
            r_vd_bf    <= i_before_far;
            r_vd_bn    <= i_before_near;
            r_vd_an    <= i_after_near;
            r_vd_af    <= i_after_far;
            r_vd_cnt   <= i_after_cnt;
        end
    end

    // Rank the checks in order of precedence
    always_comb begin
        lo_lim = PROD_W'(i_low) * PROD_W'(r_vd_len);
        hi_lim = PROD_W'(i_high) * PROD_W'(r_vd_len);
        if (r_vd_runs < LEN_W'(qrf_pkg::MIN_RUNS)) begin
            n_status = qrf_pkg::ST_FEW_RUNS;
        end else if (r_vd_index < IDX_W'(qrf_pkg::MIN_SIDE)) begin
            n_status = qrf_pkg::ST_FEW_BEFORE;
        end else if (r_vd_cnt < 2'(qrf_pkg::MIN_SIDE)) begin
            n_status = qrf_pkg::ST_FEW_AFTER;
        end else if (!ratio_ok(r_vd_bf, lo_lim, hi_lim) || !ratio_ok(r_vd_bn, lo_lim, hi_lim) ||
                     !ratio_ok(r_vd_an, lo_lim, hi_lim) || !ratio_ok(r_vd_af, lo_lim, hi_lim))
        begin
            n_status = qrf_pkg::ST_RATIO_FAIL;
        end else begin
            n_status = qrf_pkg::ST_OK;
        end
        idx_ext = (IDX_W+qrf_pkg::CIDX_W)'(r_vd_index);
        len_ext = (LEN_W+qrf_pkg::CLEN_W)'(r_vd_len);
    end

    // Output register, held while the sink stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ok) begin
            r_out_valid <= r_vd_valid;
        end
        if (out_ok && r_vd_valid) begin
            r_out_found  <= (n_status == qrf_pkg::ST_OK);
            r_out_status <= n_status;
            r_out_index  <= idx_ext[qrf_pkg::CIDX_W-1:0];
            r_out_len    <= len_ext[qrf_pkg::CLEN_W-1:0];
        end
    end

    assign res.valid         = r_out_valid;
    assign res.found         = r_out_found;
    assign res.status        = r_out_status;
    assign res.center_index  = r_out_index;
    assign res.center_length = r_out_len;

endmodule
